### sv/gng_pkg.sv
// gng_pkg: shared types, widths and codes for the grid neighbour generator.
// Used by every module of the block; depends on nothing.
package gng_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SIDE  = 256;
  localparam int DEF_MAX_CELLS = 65536;

  // Fixed field widths
  localparam int NODE_W     = 16;
  localparam int SIDE_W     = 9;
  localparam int COST_W     = 10;
  localparam int RCOST_W    = 20;
  localparam int CAND_W     = NODE_W + 1;  // node plus/minus one row
  localparam int LIM_W      = 25;          // holds cell counts up to 2**24
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Job queue depth between front and back (power of two)
  localparam int QDEPTH = 4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COST   = 2'd2;

  localparam logic [SIDE_W-1:0] RST_GRID_WIDTH  = 9'd256;
  localparam logic [SIDE_W-1:0] RST_GRID_HEIGHT = 9'd256;
  localparam logic [COST_W-1:0] RST_STEP_COST   = 10'd1;

  // Request codes on req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_NBR   = 2'd1,
    REQ_HEUR  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Job kinds after classification
  typedef enum logic [1:0] {
    K_WRITE,
    K_NBR,
    K_HEUR,
    K_ERR
  } kind_t;

  // Neighbour directions, in emission order
  typedef enum logic [1:0] {
    DIR_UP,
    DIR_LEFT,
    DIR_RIGHT,
    DIR_DOWN
  } dir_t;

  typedef struct packed {
    kind_t             kind;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] goal;
    logic              pass;
  } job_t;

  // Effective grid geometry, derived from the configuration registers
  typedef struct packed {
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [LIM_W-1:0]  cells;
    logic [COST_W-1:0] cost;
  } geom_t;

  typedef enum logic [3:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_RESULT,
    BS_DIV0,
    BS_DIV0_WAIT,
    BS_DIV1,
    BS_DIV1_WAIT,
    BS_DIST,
    BS_MUL,
    BS_READ,
    BS_READ_END,
    BS_PICK,
    BS_EMIT
  } back_state_t;

endpackage

### sv/gng_front.sv
// gng_front: input stage of the grid neighbour generator. Registers one
// request, range-checks it against the grid and pushes a job. Uses gng_pkg.
module gng_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gng_pkg::REQ_W-1:0]   req_type,
  input  logic [gng_pkg::NODE_W-1:0]  node,
  input  logic [gng_pkg::NODE_W-1:0]  goal_node,
  input  logic                        passable_bit,
  input  logic [gng_pkg::LIM_W-1:0]   cells,
  output logic                        q_push,
  output gng_pkg::job_t               q_job,
  input  logic                        q_ready
);
  import gng_pkg::*;

  logic              f_valid;
  logic [REQ_W-1:0]  f_req;
  logic [NODE_W-1:0] f_node;
  logic [NODE_W-1:0] f_goal;
  logic              f_pass;

  logic node_in;
  logic goal_in;
  logic drop;
  logic take;

  // Range checks against the current cell count
  assign node_in = LIM_W'(f_node) < cells;
  assign goal_in = LIM_W'(f_goal) < cells;

  // Classify the held request
  always_comb begin
    drop       = 1'b0;
    q_job.node = f_node;
    q_job.goal = f_goal;
    q_job.pass = f_pass;
    case (req_t'(f_req))
      REQ_WRITE: q_job.kind = node_in ? K_WRITE : K_ERR;
      REQ_NBR:   q_job.kind = node_in ? K_NBR : K_ERR;
      REQ_HEUR:  q_job.kind = (node_in && goal_in) ? K_HEUR : K_ERR;
      default: begin
        q_job.kind = K_ERR;
        drop       = 1'b1;  // unused code: consumed, nothing queued
      end
    endcase
  end

  assign q_push   = f_valid && !drop && q_ready;
  assign take     = f_valid && (drop || q_ready);
  assign in_ready = !f_valid || take;

  // Holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_req  <= req_type;
      f_node <= node;
      f_goal <= goal_node;
      f_pass <= passable_bit;
    end
  end

endmodule

### sv/gng_queue.sv
// gng_queue: short first-word-fall-through job queue between the front and
// back of the grid neighbour generator. Uses gng_pkg.
module gng_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gng_pkg::job_t push_job,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output gng_pkg::job_t head
);
  import gng_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = PTR_W + 1;

  job_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign ready   = count != CNT_W'(QDEPTH);
  assign valid   = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  // Pointers wrap naturally since the depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

### sv/gng_div.sv
// gng_div: iterative unsigned divider, node index by grid width, two
// quotient bits per cycle. Uses gng_pkg.
module gng_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gng_pkg::NODE_W-1:0]  dividend,
  input  logic [gng_pkg::SIDE_W-1:0]  divisor,
  output logic                        done,
  output logic [gng_pkg::NODE_W-1:0]  quot,
  output logic [gng_pkg::SIDE_W-1:0]  rem
);
  import gng_pkg::*;

  localparam int BITS_PER_CYC = 2;
  localparam int STEPS        = NODE_W / BITS_PER_CYC;
  localparam int CNT_W        = $clog2(STEPS);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [NODE_W-1:0] shq;     // dividend shifts out, quotient shifts in
  logic [SIDE_W-1:0] rem_r;
  logic [SIDE_W-1:0] dvs;
  logic [NODE_W-1:0] shq_next;
  logic [SIDE_W-1:0] rem_next;

  // Two restoring steps per cycle
  always_comb begin
    logic [SIDE_W:0] t;
    shq_next = shq;
    rem_next = rem_r;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      t        = {rem_next, shq_next[NODE_W-1]};
      shq_next = {shq_next[NODE_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t           = t - {1'b0, dvs};
        shq_next[0] = 1'b1;
      end
      rem_next = t[SIDE_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shq   <= dividend;
      rem_r <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shq   <= shq_next;
      rem_r <= rem_next;
    end
  end

  assign quot = shq;
  assign rem  = rem_r;

endmodule

### sv/gng_back.sv
// gng_back: job sequencer of the grid neighbour generator. Holds the
// passability bitmap, runs the divider and drives the result register.
// Uses gng_pkg and gng_div.
module gng_back #(
  parameter int MAX_CELLS = gng_pkg::DEF_MAX_CELLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gng_pkg::geom_t              geom,
  input  logic                        q_valid,
  input  gng_pkg::job_t               q_job,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic                        has_item,
  output logic [gng_pkg::NODE_W-1:0]  neighbour_node,
  output logic [gng_pkg::RCOST_W-1:0] cost,
  output logic                        last
);
  import gng_pkg::*;

  localparam int AW     = $clog2(MAX_CELLS);
  localparam int NREAD  = 5;               // center plus four neighbours
  localparam int RIDX_W = $clog2(NREAD);
  localparam logic [RIDX_W-1:0] RD_LAST = RIDX_W'(NREAD - 1);
  localparam int PROD_W = CAND_W + COST_W;

  back_state_t state, state_next;

  // Bitmap, single port, registered read
  logic          map_bits [MAX_CELLS];
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic          mem_wd;
  logic          mem_rd;
  logic [AW-1:0] clr_cnt;

  // Divider
  logic              div_start;
  logic [NODE_W-1:0] div_dividend;
  logic              div_done;
  logic [NODE_W-1:0] div_quot;
  logic [SIDE_W-1:0] div_rem;

  // Working registers
  job_t               job_r;
  logic [NODE_W-1:0]  q0_r;
  logic [SIDE_W-1:0]  r0_r;
  logic [3:0]         geo_r;
  logic [3:0]         mask_r;
  logic [NREAD-1:0]   rd_bits;
  logic [RIDX_W-1:0]  rd_idx;
  logic [CAND_W-1:0]  dist_r;
  logic               res_status;
  logic               res_has;
  logic [RCOST_W-1:0] res_cost;

  // Combinational helpers
  logic [3:0]         geo_now;
  logic [3:0]         pick_mask;
  dir_t               sel;
  logic [3:0]         sel_oh;
  logic [CAND_W-1:0]  cand_right;
  logic [CAND_W-1:0]  cand_down;
  logic [CAND_W-1:0]  cand_sel;
  logic [CAND_W-1:0]  cand_rd;
  logic [SIDE_W-1:0]  dx;
  logic [NODE_W-1:0]  dy;
  logic [PROD_W-1:0]  prod;
  logic               out_load;
  logic               emit_valid;
  logic               emit_status;
  logic               emit_has;
  logic [NODE_W-1:0]  emit_nb;
  logic [RCOST_W-1:0] emit_cost;
  logic               emit_last;

  function automatic logic [CAND_W-1:0] cand_of(input dir_t dir,
                                                 input logic [NODE_W-1:0] n,
                                                 input logic [SIDE_W-1:0] w);
    logic [CAND_W-1:0] nn;
    logic [CAND_W-1:0] ww;
    nn = CAND_W'(n);
    ww = CAND_W'(w);
    case (dir)
      DIR_UP:    cand_of = nn - ww;
      DIR_LEFT:  cand_of = nn - CAND_W'(1);
      DIR_RIGHT: cand_of = nn + CAND_W'(1);
      DIR_DOWN:  cand_of = nn + ww;
      default:   cand_of = nn;
    endcase
  endfunction

  gng_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (geom.w),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // In-grid neighbour directions, from quotient (row) and remainder (column)
  assign cand_right = cand_of(DIR_RIGHT, job_r.node, geom.w);
  assign cand_down  = cand_of(DIR_DOWN, job_r.node, geom.w);

  always_comb begin
    geo_now[DIR_UP]    = div_quot != '0;
    geo_now[DIR_LEFT]  = div_rem != '0;
    geo_now[DIR_RIGHT] = (CAND_W'(div_rem) + CAND_W'(1) < CAND_W'(geom.w)) &&
                         (LIM_W'(cand_right) < geom.cells);
    geo_now[DIR_DOWN]  = (CAND_W'(div_quot) + CAND_W'(1) < CAND_W'(geom.h)) &&
                         (LIM_W'(cand_down) < geom.cells);
  end

  // Open neighbours of an open center cell
  assign pick_mask = geo_r & rd_bits[NREAD-1:1] & {4{rd_bits[0]}};

  // Lowest pending direction goes out first
  always_comb begin
    sel = DIR_UP;
    for (int i = 3; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = dir_t'(i);
      end
    end
    sel_oh = 4'b0001 << sel;
  end

  assign cand_sel = cand_of(sel, job_r.node, geom.w);
  assign cand_rd  = cand_of(dir_t'(rd_idx - RIDX_W'(1)), job_r.node, geom.w);

  // Manhattan distance between node (held) and goal (divider output)
  assign dx   = (r0_r > div_rem) ? r0_r - div_rem : div_rem - r0_r;
  assign dy   = (q0_r > div_quot) ? q0_r - div_quot : div_quot - q0_r;
  assign prod = dist_r * geom.cost;

  assign out_load = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BS_CLEAR: begin
        if (clr_cnt == AW'(MAX_CELLS - 1)) begin
          state_next = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_valid) begin
          if (q_job.kind == K_NBR || q_job.kind == K_HEUR) begin
            state_next = BS_DIV0;
          end else begin
            state_next = BS_RESULT;
          end
        end
      end
      BS_RESULT: begin
        if (out_load) begin
          state_next = BS_IDLE;
        end
      end
      BS_DIV0: state_next = BS_DIV0_WAIT;
      BS_DIV0_WAIT: begin
        if (div_done) begin
          state_next = (job_r.kind == K_NBR) ? BS_READ : BS_DIV1;
        end
      end
      BS_DIV1: state_next = BS_DIV1_WAIT;
      BS_DIV1_WAIT: begin
        if (div_done) begin
          state_next = BS_DIST;
        end
      end
      BS_DIST: state_next = BS_MUL;
      BS_MUL:  state_next = BS_RESULT;
      BS_READ: begin
        if (rd_idx == RD_LAST) begin
          state_next = BS_READ_END;
        end
      end
      BS_READ_END: state_next = BS_PICK;
      BS_PICK: state_next = (pick_mask == '0) ? BS_RESULT : BS_EMIT;
      BS_EMIT: begin
        if (out_load && emit_last) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  // State outputs: bitmap port, divider start, queue pop, result
  always_comb begin
    mem_addr     = AW'(job_r.node);
    mem_we       = 1'b0;
    mem_wd       = 1'b0;
    div_start    = 1'b0;
    div_dividend = job_r.node;
    q_pop        = 1'b0;
    emit_valid   = 1'b0;
    emit_status  = res_status;
    emit_has     = res_has;
    emit_nb      = '0;
    emit_cost    = res_cost;
    emit_last    = 1'b1;
    case (state)
      BS_CLEAR: begin
        mem_addr = clr_cnt;
        mem_we   = 1'b1;
      end
      BS_IDLE: begin
        q_pop    = q_valid;
        mem_addr = AW'(q_job.node);
        mem_we   = q_valid && (q_job.kind == K_WRITE);
        mem_wd   = q_job.pass;
      end
      BS_DIV0: div_start = 1'b1;
      BS_DIV1: begin
        div_start    = 1'b1;
        div_dividend = job_r.goal;
      end
      BS_READ: begin
        if (rd_idx != '0) begin
          mem_addr = AW'(cand_rd);
        end
      end
      BS_RESULT: emit_valid = 1'b1;
      BS_EMIT: begin
        emit_valid  = 1'b1;
        emit_status = 1'b0;
        emit_has    = 1'b1;
        emit_nb     = cand_sel[NODE_W-1:0];
        emit_cost   = RCOST_W'(geom.cost);
        emit_last   = (mask_r & ~sel_oh) == '0;
      end
      default: ;
    endcase
  end

  // Bitmap
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_bits[mem_addr] <= mem_wd;
    end
    mem_rd <= map_bits[mem_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BS_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == BS_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      BS_IDLE: begin
        job_r      <= q_job;
        res_status <= q_job.kind == K_ERR;
        res_has    <= 1'b0;
        res_cost   <= '0;
      end
      BS_DIV0_WAIT: begin
        if (div_done) begin
          q0_r   <= div_quot;
          r0_r   <= div_rem;
          geo_r  <= geo_now;
          rd_idx <= '0;
        end
      end
      BS_READ: begin
        rd_idx <= rd_idx + RIDX_W'(1);
        if (rd_idx != '0) begin
          rd_bits <= {mem_rd, rd_bits[NREAD-1:1]};
        end
      end
      BS_READ_END: rd_bits <= {mem_rd, rd_bits[NREAD-1:1]};
      BS_PICK:     mask_r <= pick_mask;
      BS_EMIT: begin
        if (out_load) begin
          mask_r <= mask_r & ~sel_oh;
        end
      end
      BS_DIST: dist_r <= CAND_W'(dx) + CAND_W'(dy);
      BS_MUL: begin
        res_cost <= prod[RCOST_W-1:0];
        res_has  <= 1'b1;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && emit_valid) begin
      status         <= emit_status;
      has_item       <= emit_has;
      neighbour_node <= emit_nb;
      cost           <= emit_cost;
      last           <= emit_last;
    end
  end

endmodule

### sv/grid_neighbour_generator.sv
// grid_neighbour_generator: top level. Configuration registers, grid
// geometry, and the front / queue / back split. Uses gng_pkg and all gng_*.
//
// Rate: after reset the bitmap is cleared one cell per cycle, all MAX_CELLS
// cells (65536 by default), during which requests queue up but none
// complete. Cell writes and out-of-grid requests then go from idle straight
// to the result state. A neighbour query runs the node-by-width division
// (radix-4 divider, 8 iterations) and five reads of the single-port bitmap,
// then emits each open neighbour in turn as out_ready allows. A heuristic
// query runs the same divider twice and a multiply. The input stage and a
// 4-entry job queue accept new transactions while the back end is busy.
module grid_neighbour_generator #(
  parameter int MAX_SIDE  = gng_pkg::DEF_MAX_SIDE,
  parameter int MAX_CELLS = gng_pkg::DEF_MAX_CELLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gng_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gng_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gng_pkg::REQ_W-1:0]       req_type,
  input  logic [gng_pkg::NODE_W-1:0]      node,
  input  logic [gng_pkg::NODE_W-1:0]      goal_node,
  input  logic                            passable_bit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            status,
  output logic                            has_item,
  output logic [gng_pkg::NODE_W-1:0]      neighbour_node,
  output logic [gng_pkg::RCOST_W-1:0]     cost,
  output logic                            last
);
  import gng_pkg::*;

  localparam int SIDE_CODE_MAX = (1 << SIDE_W) - 1;
  localparam logic [SIDE_W-1:0] SIDE_CAP =
    (MAX_SIDE > SIDE_CODE_MAX) ? SIDE_W'(SIDE_CODE_MAX) : SIDE_W'(MAX_SIDE);
  localparam logic [LIM_W-1:0] CELL_CAP = LIM_W'(MAX_CELLS);

  logic [SIDE_W-1:0]   grid_width;
  logic [SIDE_W-1:0]   grid_height;
  logic [COST_W-1:0]   step_cost;
  logic [SIDE_W-1:0]   w_eff;
  logic [SIDE_W-1:0]   h_eff;
  logic [2*SIDE_W-1:0] area;
  geom_t               geom;

  logic q_push;
  job_t q_push_job;
  logic q_ready;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RST_GRID_WIDTH;
      grid_height <= RST_GRID_HEIGHT;
      step_cost   <= RST_STEP_COST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[SIDE_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[SIDE_W-1:0];
        CFG_STEP_COST:   step_cost   <= cfg_data[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sides: zero reads as one, large values clamp to MAX_SIDE
  assign w_eff = (grid_width == '0) ? SIDE_W'(1) :
                 (grid_width > SIDE_CAP) ? SIDE_CAP : grid_width;
  assign h_eff = (grid_height == '0) ? SIDE_W'(1) :
                 (grid_height > SIDE_CAP) ? SIDE_CAP : grid_height;
  assign area  = w_eff * h_eff;

  always_comb begin
    geom.w     = w_eff;
    geom.h     = h_eff;
    geom.cells = (LIM_W'(area) > CELL_CAP) ? CELL_CAP : LIM_W'(area);
    geom.cost  = step_cost;
  end

  gng_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .node         (node),
    .goal_node    (goal_node),
    .passable_bit (passable_bit),
    .cells        (geom.cells),
    .q_push       (q_push),
    .q_job        (q_push_job),
    .q_ready      (q_ready)
  );

  gng_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  gng_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .geom           (geom),
    .q_valid        (q_valid),
    .q_job          (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .has_item       (has_item),
    .neighbour_node (neighbour_node),
    .cost           (cost),
    .last           (last)
  );

  // Back end only takes jobs that are there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // Error results carry no neighbour and end the transaction
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !has_item && last)
    else $error("error result with payload or not last");

  // A result without an item is always the only one of its transaction
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_item |-> last)
    else $error("empty result not marked last");

endmodule
